FILE: hdl/ppwu_pkg.sv
package ppwu_pkg;

	// Limits of the pixel address space
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Field widths
	localparam int DIM_W    = 11;	// line_width / frame_height registers
	localparam int COORD_W  = 10;	// goto and output coordinates
	localparam int WORD_W   = 32;
	localparam int RGB_W    = 24;
	localparam int COLOUR_W = 32;
	localparam int PIX_IDX_W = 5;	// up to 32 pixels per word

	localparam int IN_DATA_W  = 56;	// 32 + 10 + 10, padded to bytes
	localparam int OUT_DATA_W = 56;	// 10 + 10 + 32, padded to bytes

	localparam int Q_DEPTH = 2;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	typedef enum logic [1:0] {
		CMD_PIXEL = 2'd0,
		CMD_HOME  = 2'd1,
		CMD_GOTO  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		DEPTH_1BPP  = 2'd0,
		DEPTH_332   = 2'd1,
		DEPTH_565   = 2'd2,
		DEPTH_24BPP = 2'd3
	} depth_t;

	typedef enum logic [1:0] {
		REG_LINE_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_DEPTH_MODE   = 2'd2,
		REG_SB_COLOUR    = 2'd3
	} reg_idx_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_DRAW = 1'b1
	} bk_state_t;

	typedef struct packed {
		logic [DIM_W-1:0] line_width;
		logic [DIM_W-1:0] frame_height;
		depth_t           depth_mode;
		logic [RGB_W-1:0] single_bit_colour;
	} cfg_t;

	typedef struct packed {
		cmd_t               op;
		logic [WORD_W-1:0]  word;
		logic [COORD_W-1:0] gx;
		logic [COORD_W-1:0] gy;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic                 busy;
		logic [PIX_IDX_W-1:0] k;
		logic [PIX_IDX_W-1:0] last_k;
	} bk_stat_t;

	// Index of the final pixel slot in a word for each depth
	function automatic logic [PIX_IDX_W-1:0] last_slot(depth_t d);
		logic [PIX_IDX_W-1:0] r;
		case (d)
			DEPTH_1BPP:  r = 5'd31;
			DEPTH_332:   r = 5'd3;
			DEPTH_565:   r = 5'd1;
			default:     r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [RGB_W-1:0] expand_332(logic [7:0] i);
		return {i[7:5], 5'd0, i[4:2], 5'd0, i[1:0], 6'd0};
	endfunction

	function automatic logic [RGB_W-1:0] expand_565(logic [15:0] d);
		return {d[15:11], 3'd0, d[10:5], 2'd0, d[4:0], 3'd0};
	endfunction

endpackage

FILE: hdl/ppwu_front.sv
module ppwu_front (
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [ppwu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [1:0]                      s_axis_tuser,
	input  ppwu_pkg::q_stat_t               q_stat,
	output logic                            q_push,
	output ppwu_pkg::q_entry_t              q_entry
);
	import ppwu_pkg::*;

	cmd_t cmd;

	assign cmd           = cmd_t'(s_axis_tuser);
	assign s_axis_tready = !q_stat.full;

	// NOP commands (cmd 3) are swallowed here; everything else is queued in order.
	always_comb begin
		q_entry.op   = cmd;
		q_entry.word = s_axis_tdata[WORD_W-1:0];
		q_entry.gx   = s_axis_tdata[WORD_W +: COORD_W];
		q_entry.gy   = s_axis_tdata[WORD_W+COORD_W +: COORD_W];
		q_push       = s_axis_tvalid && s_axis_tready && (cmd != CMD_NOP);
	end

endmodule

FILE: hdl/ppwu_queue.sv
module ppwu_queue #(
	parameter int DEPTH = ppwu_pkg::Q_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ppwu_pkg::q_entry_t  push_entry,
	input  logic                pop,
	output ppwu_pkg::q_entry_t  head,
	output ppwu_pkg::q_stat_t   stat
);
	import ppwu_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t          mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] inc_ptr(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= inc_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= inc_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/ppwu_back.sv
module ppwu_back #(
	parameter int MAX_WIDTH  = ppwu_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ppwu_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ppwu_pkg::cfg_t                   cfg,
	input  ppwu_pkg::q_entry_t               head,
	input  ppwu_pkg::q_stat_t                q_stat,
	output logic                             q_pop,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [ppwu_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tlast,
	output ppwu_pkg::bk_stat_t               stat
);
	import ppwu_pkg::*;

	// Cursor can only pass 1023 when the limit allows it
	localparam int CX_W = (MAX_WIDTH  > 1024) ? DIM_W : COORD_W;
	localparam int CY_W = (MAX_HEIGHT > 1024) ? DIM_W : COORD_W;
	localparam int WW   = ($clog2(MAX_WIDTH + 1)  > DIM_W) ? $clog2(MAX_WIDTH + 1)  : DIM_W;
	localparam int HW   = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;

	bk_state_t            state_q, state_d;
	logic [WORD_W-1:0]    word_q, word_d;
	logic [PIX_IDX_W-1:0] k_q, k_d;
	logic [CX_W-1:0]      cur_x_q, cur_x_d;
	logic [CY_W-1:0]      cur_y_q, cur_y_d;

	logic                 ov_q, ov_d;
	logic [COORD_W-1:0]   ox_q, ox_d;
	logic [COORD_W-1:0]   oy_q, oy_d;
	logic [COLOUR_W-1:0]  ocol_q, ocol_d;
	logic                 olast_q, olast_d;

	logic [WW-1:0]        eff_w;
	logic [HW-1:0]        eff_h;
	logic [PIX_IDX_W-1:0] last_k;
	logic                 can_out;
	logic                 wrap;
	logic [RGB_W-1:0]     rgb;
	logic [7:0]           sb_byte;

	assign eff_w  = (WW'(cfg.line_width) < WW'(MAX_WIDTH)) ? WW'(cfg.line_width)
	                                                        : WW'(MAX_WIDTH);
	assign eff_h  = (HW'(cfg.frame_height) < HW'(MAX_HEIGHT)) ? HW'(cfg.frame_height)
	                                                           : HW'(MAX_HEIGHT);
	assign last_k = last_slot(cfg.depth_mode);
	assign can_out = !ov_q || m_axis_tready;
	assign wrap    = (WW'(cur_x_q) + 1'b1) >= eff_w;
	assign sb_byte = word_q[k_q[4:3]*8 +: 8];

	// Pixel selector for the current slot
	always_comb begin
		case (cfg.depth_mode)
			DEPTH_1BPP: rgb = sb_byte[~k_q[2:0]] ? cfg.single_bit_colour : '0;
			DEPTH_332:  rgb = expand_332(word_q[k_q[1:0]*8 +: 8]);
			DEPTH_565:  rgb = expand_565(word_q[k_q[0]*16 +: 16]);
			default:    rgb = word_q[RGB_W-1:0];
		endcase
	end

	always_comb begin
		state_d = state_q;
		word_d  = word_q;
		k_d     = k_q;
		cur_x_d = cur_x_q;
		cur_y_d = cur_y_q;
		ov_d    = ov_q && !m_axis_tready;
		ox_d    = ox_q;
		oy_d    = oy_q;
		ocol_d  = ocol_q;
		olast_d = olast_q;
		q_pop   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					q_pop = 1'b1;
					case (head.op)
						CMD_PIXEL: begin
							word_d  = head.word;
							k_d     = '0;
							state_d = BK_DRAW;
						end
						CMD_HOME: begin
							cur_x_d = '0;
							cur_y_d = '0;
						end
						CMD_GOTO: begin
							if (WW'(head.gx) < eff_w) begin
								cur_x_d = CX_W'(head.gx);
							end
							if (HW'(head.gy) < eff_h) begin
								cur_y_d = CY_W'(head.gy);
							end
						end
						default: ;
					endcase
				end
			end
			BK_DRAW: begin
				if (can_out) begin
					ov_d    = 1'b1;
					ox_d    = cur_x_q[COORD_W-1:0];
					oy_d    = cur_y_q[COORD_W-1:0];
					ocol_d  = {ALPHA_OPAQUE, rgb};
					olast_d = wrap || (k_q == last_k);
					if (wrap) begin
						cur_x_d = '0;
						cur_y_d = ((HW'(cur_y_q) + 1'b1) >= eff_h) ? '0 : cur_y_q + 1'b1;
					end else begin
						cur_x_d = cur_x_q + 1'b1;
					end
					k_d = k_q + 1'b1;
					if (olast_d) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cur_x_q <= '0;
			cur_y_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_x_q <= cur_x_d;
			cur_y_q <= cur_y_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		word_q  <= word_d;
		k_q     <= k_d;
		ox_q    <= ox_d;
		oy_q    <= oy_d;
		ocol_q  <= ocol_d;
		olast_q <= olast_d;
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {4'b0, ocol_q, oy_q, ox_q};
	assign m_axis_tlast  = olast_q;

	assign stat.busy   = (state_q == BK_DRAW);
	assign stat.k      = k_q;
	assign stat.last_k = last_k;

endmodule

FILE: hdl/packed_pixel_word_unpacker.sv
// Packed pixel word unpacker: each input beat carries a command in tuser. A pixel word
// (cmd 0) holds 32, 4, 2 or 1 pixels at 1, 8 (R3G3B2), 16 (RGB565) or 24 bits, low byte
// first (1-bit mode: bit 7 of each byte first). Every pixel leaves as one output beat with
// its cursor position and an ARGB8888 colour, alpha 0xff; tlast marks the final pixel of
// the word. The cursor steps one column per pixel; at the line end it goes to the start of
// the next line and the rest of the word is dropped, and the line wraps at the frame end.
// Home (cmd 1) zeroes the cursor, goto (cmd 2) moves each coordinate only if it is inside
// the current limits, cmd 3 is ignored. Commands give no output. Rate: a word is popped
// from the 2-deep queue, then the back end's single pixel stage emits one pixel per cycle
// while the output is not stalled; the next item waits for the word's end. Configuration must
// be written only while the block is idle and the queue is drained (not enforced here).
module packed_pixel_word_unpacker #(
	parameter int MAX_WIDTH  = ppwu_pkg::MAX_WIDTH_DEF,	// 16..4096
	parameter int MAX_HEIGHT = ppwu_pkg::MAX_HEIGHT_DEF	// 16..4096
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [ppwu_pkg::RGB_W-1:0]      cfg_data,

	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// pixel_word[31:0], goto_x[41:32], goto_y[51:42], zero pad
	input  logic [ppwu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// cmd[1:0]
	input  logic [1:0]                      s_axis_tuser,

	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// pixel_x[9:0], pixel_y[19:10], colour[51:20], zero pad
	output logic [ppwu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tlast
);
	import ppwu_pkg::*;

	cfg_t     cfg_q;
	q_stat_t  q_stat;
	q_entry_t q_in;
	q_entry_t q_head;
	logic     q_push;
	logic     q_pop;
	bk_stat_t bk_stat;

	// Config registers; widths truncate the write data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_width        <= DIM_W'(320);
			cfg_q.frame_height      <= DIM_W'(240);
			cfg_q.depth_mode        <= DEPTH_24BPP;
			cfg_q.single_bit_colour <= 24'h00ff00;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LINE_WIDTH:   cfg_q.line_width        <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height      <= cfg_data[DIM_W-1:0];
				REG_DEPTH_MODE:   cfg_q.depth_mode        <= depth_t'(cfg_data[1:0]);
				REG_SB_COLOUR:    cfg_q.single_bit_colour <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end: accept and classify
	ppwu_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_entry       (q_in)
	);

	// Decoupling queue
	ppwu_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.pop        (q_pop),
		.head       (q_head),
		.stat       (q_stat)
	);

	// Back end: cursor, unpacking, output register
	ppwu_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head          (q_head),
		.q_stat        (q_stat),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.stat          (bk_stat)
	);

	// Queue can't be both full and empty
	a_q_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty together");

	// Slot index never runs past the last slot of the word
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.busy |-> (bk_stat.k <= bk_stat.last_k))
		else $error("pixel slot past end of word");

	// Popping a pixel word starts drawing
	a_pop_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_stat.empty && q_head.op == CMD_PIXEL) |=> bk_stat.busy)
		else $error("pixel word popped but back end idle");

	// No pop while a word is being drawn
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.busy |-> !q_pop)
		else $error("queue popped during draw");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import ppwu_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 3;
	localparam int CYCLE_LIMIT   = 1_000_000;
	// settle time after the last pending pixel, with margin for the worst word
	localparam int SETTLE_CYCLES = 40;
	localparam int BLOCK_ITEMS   = 17;

	// one pixel write as it should leave the block
	typedef struct {
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic [COLOUR_W-1:0] colour;
		logic                last;
	} pixel_write_t;

	// Tracks cursor and registers, turns each accepted beat into pixel writes,
	// and checks output beats against them in order.
	class pixel_write_board;
		logic [DIM_W-1:0] line_width;
		logic [DIM_W-1:0] frame_height;
		depth_t           depth;
		logic [RGB_W-1:0] sb_colour;
		int               cur_x;
		int               cur_y;
		pixel_write_t     pending_pixels[$];
		int               mismatches;

		function new();
			line_width   = 11'd320;
			frame_height = 11'd240;
			depth        = DEPTH_24BPP;
			sb_colour    = 24'h00ff00;
			cur_x        = 0;
			cur_y        = 0;
			mismatches   = 0;
		endfunction

		function int line_limit();
			return (line_width < MAX_WIDTH_DEF) ? int'(line_width) : MAX_WIDTH_DEF;
		endfunction

		function int frame_limit();
			return (frame_height < MAX_HEIGHT_DEF) ? int'(frame_height) : MAX_HEIGHT_DEF;
		endfunction

		function void set_reg(reg_idx_t idx, logic [RGB_W-1:0] value);
			case (idx)
				REG_LINE_WIDTH:   line_width = value[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height = value[DIM_W-1:0];
				REG_DEPTH_MODE:   depth = depth_t'(value[1:0]);
				default:          sb_colour = value;
			endcase
		endfunction

		function void take_item(cmd_t op, logic [WORD_W-1:0] w, logic [COORD_W-1:0] gx,
				logic [COORD_W-1:0] gy);
			int               wlim;
			int               hlim;
			int               slots;
			int               k;
			int unsigned      v;
			logic [RGB_W-1:0] rgb;
			pixel_write_t     px;
			bit               wrapped;
			wlim = line_limit();
			hlim = frame_limit();
			case (op)
				CMD_HOME: begin
					cur_x = 0;
					cur_y = 0;
				end
				CMD_GOTO: begin
					// each coordinate moves only when inside its limit
					if (int'(gx) < wlim)
						cur_x = int'(gx);
					if (int'(gy) < hlim)
						cur_y = int'(gy);
				end
				CMD_PIXEL: begin
					case (depth)
						DEPTH_1BPP: slots = 32;
						DEPTH_332:  slots = 4;
						DEPTH_565:  slots = 2;
						default:    slots = 1;
					endcase
					for (k = 0; k < slots; k++) begin
						case (depth)
							DEPTH_1BPP: begin
								// byte by byte, msb of each byte first
								rgb = w[8 * (k / 8) + 7 - (k % 8)] ? sb_colour : '0;
							end
							DEPTH_332: begin
								v = (w >> (8 * k)) & 32'hFF;
								rgb = RGB_W'(((v & 32'hE0) << 16) | ((v & 32'h1C) << 11) |
									((v & 32'h03) << 6));
							end
							DEPTH_565: begin
								v = (w >> (16 * k)) & 32'hFFFF;
								rgb = RGB_W'(((v & 32'hF800) << 8) | ((v & 32'h07E0) << 5) |
									((v & 32'h001F) << 3));
							end
							default: rgb = w[RGB_W-1:0];
						endcase
						px.x      = COORD_W'(cur_x);
						px.y      = COORD_W'(cur_y);
						px.colour = {ALPHA_OPAQUE, rgb};
						// >= so a cursor left past a shrunk limit wraps on its next pixel
						wrapped = (cur_x + 1 >= wlim);
						if (wrapped) begin
							cur_x = 0;
							cur_y = (cur_y + 1 >= hlim) ? 0 : cur_y + 1;
						end else begin
							cur_x++;
						end
						// line wrap drops the rest of the word
						px.last = wrapped || (k + 1 == slots);
						pending_pixels.push_back(px);
						if (px.last)
							break;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_pixel(logic [OUT_DATA_W-1:0] data, logic last);
			pixel_write_t want;
			logic [COORD_W-1:0]  got_x;
			logic [COORD_W-1:0]  got_y;
			logic [COLOUR_W-1:0] got_colour;
			got_x      = data[COORD_W-1:0];
			got_y      = data[2*COORD_W-1:COORD_W];
			got_colour = data[2*COORD_W +: COLOUR_W];
			if (pending_pixels.size() == 0) begin
				$error("pixel beat with none pending: x %0d y %0d colour %h last %0b",
					got_x, got_y, got_colour, last);
				mismatches++;
				return;
			end
			want = pending_pixels.pop_front();
			if (got_x !== want.x) begin
				$error("pixel_x: expected %0d, actual %0d", want.x, got_x);
				mismatches++;
			end
			if (got_y !== want.y) begin
				$error("pixel_y: expected %0d, actual %0d", want.y, got_y);
				mismatches++;
			end
			if (got_colour !== want.colour) begin
				$error("colour: expected %h, actual %h", want.colour, got_colour);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [1:0]            cfg_index = '0;
	logic [RGB_W-1:0]      cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;	// pixel_word, goto_x, goto_y, pad
	logic [1:0]            s_axis_tuser = '0;	// cmd
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;	// pixel_x, pixel_y, colour, pad
	logic                  m_axis_tlast;

	pixel_write_board board;
	int send_idle_pct = 11;
	int recv_idle_pct = 77;

	packed_pixel_word_unpacker uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #CLK_HALF clk = ~clk;

	// output side: check each accepted beat, then pick next cycle's ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				board.check_pixel(m_axis_tdata, m_axis_tlast);
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	task automatic send_beat(cmd_t op, logic [WORD_W-1:0] w, logic [COORD_W-1:0] gx,
			logic [COORD_W-1:0] gy);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_DATA_W'({gy, gx, w});
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.take_item(op, w, gx, gy);
	endtask

	// hold off until every pending pixel has left and the block has settled
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (board.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(reg_idx_t idx, logic [RGB_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		board.set_reg(idx, value);
	endtask

	task automatic write_regs(int lw, int fh, depth_t d, logic [RGB_W-1:0] sbc);
		wait_idle();
		put_reg(REG_LINE_WIDTH, RGB_W'(lw));
		put_reg(REG_FRAME_HEIGHT, RGB_W'(fh));
		put_reg(REG_DEPTH_MODE, RGB_W'(d));
		put_reg(REG_SB_COLOUR, sbc);
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_limit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 40);
		else if (r < 80)
			return MAX_WIDTH_DEF;
		else if (r < 85)
			return 0;
		else if (r < 90)
			return 2047;
		return $urandom_range(1, 2047);
	endfunction

	// fresh register setting, then a block of mostly pixel words
	task automatic random_block();
		int          r;
		int          lim;
		cmd_t        op;
		logic [31:0] w;
		logic [9:0]  gx;
		logic [9:0]  gy;
		write_regs(pick_limit(), pick_limit(), depth_t'($urandom_range(0, 3)),
			RGB_W'($urandom));
		for (int i = 0; i < BLOCK_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 72)
				op = CMD_PIXEL;
			else if (r < 84)
				op = CMD_GOTO;
			else if (r < 93)
				op = CMD_HOME;
			else
				op = CMD_NOP;
			case ($urandom_range(0, 9))
				0:       w = '0;
				1:       w = '1;
				default: w = $urandom;
			endcase
			gx = COORD_W'($urandom_range(0, 1023));
			gy = COORD_W'($urandom_range(0, 1023));
			// half the gotos land inside the current limits
			if ($urandom_range(0, 1)) begin
				lim = board.line_limit();
				if (lim > 0)
					gx = COORD_W'($urandom_range(0, lim - 1));
				lim = board.frame_limit();
				if (lim > 0)
					gy = COORD_W'($urandom_range(0, lim - 1));
			end
			send_beat(op, w, gx, gy);
		end
	endtask

	initial begin
		board = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: 320x240, 24 bit, top byte of the word ignored
		send_beat(CMD_PIXEL, 32'hA5123456, '0, '0);
		send_beat(CMD_PIXEL, 32'h00000000, '0, '0);
		send_beat(CMD_NOP, 32'hFFFFFFFF, 10'h3FF, 10'h3FF);
		// last pixel of the frame wraps both coordinates
		send_beat(CMD_GOTO, '0, 10'd319, 10'd239);
		send_beat(CMD_PIXEL, 32'h00FFFFFF, '0, '0);
		// x out of range stays put, y moves
		send_beat(CMD_GOTO, '0, 10'd320, 10'd5);
		send_beat(CMD_PIXEL, 32'h12345678, '0, '0);
		send_beat(CMD_HOME, '0, '0, '0);
		send_beat(CMD_PIXEL, 32'hFFFFFFFF, '0, '0);

		// tiny 1-bit frame: line wrap drops the rest of each word
		write_regs(4, 3, DEPTH_1BPP, 24'hFFFFFF);
		send_beat(CMD_PIXEL, 32'h80000001, '0, '0);
		send_beat(CMD_PIXEL, 32'hF0F0F0F0, '0, '0);
		send_beat(CMD_PIXEL, 32'h0F0F0F0F, '0, '0);
		send_beat(CMD_GOTO, '0, 10'd3, 10'd2);
		send_beat(CMD_PIXEL, 32'hFFFFFFFF, '0, '0);

		// full-size frame, R3G3B2, corner of the address space
		write_regs(MAX_WIDTH_DEF, MAX_HEIGHT_DEF, DEPTH_332, 24'h000000);
		send_beat(CMD_GOTO, '0, 10'd1022, 10'd1023);
		send_beat(CMD_PIXEL, 32'hFFE31C03, '0, '0);
		send_beat(CMD_PIXEL, 32'h1CE003FF, '0, '0);
		send_beat(CMD_GOTO, '0, 10'd1000, 10'd500);

		// shrink limits under the cursor: it wraps on its next pixel
		write_regs(16, 16, DEPTH_565, 24'h5A5A5A);
		send_beat(CMD_PIXEL, 32'hF80007E0, '0, '0);
		send_beat(CMD_PIXEL, 32'h001FFFFF, '0, '0);

		// zero width wraps at every pixel; height above the max is clamped
		write_regs(0, 2047, DEPTH_1BPP, 24'h123456);
		send_beat(CMD_PIXEL, 32'h80000000, '0, '0);
		send_beat(CMD_GOTO, '0, 10'd0, 10'd1023);
		send_beat(CMD_PIXEL, 32'h00000080, '0, '0);

		// width above the max is clamped; zero height keeps line 0
		write_regs(2047, 0, DEPTH_24BPP, 24'h000000);
		send_beat(CMD_PIXEL, 32'h00ABCDEF, '0, '0);
		send_beat(CMD_GOTO, '0, 10'd1023, 10'd0);
		send_beat(CMD_PIXEL, 32'hFF000001, '0, '0);

		repeat (3) random_block();

		send_idle_pct = 77;
		recv_idle_pct = 11;
		repeat (3) random_block();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (3) random_block();

		wait_idle();
		if (board.mismatches == 0 && board.pending_pixels.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
